// ===== rtl/pbrl_pkg.sv =====
// Shared types and constants for the point box to rank lookup block.
package pbrl_pkg;

	localparam int unsigned CFG_IW = 2;
	localparam int unsigned CFG_DW = 5;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned RADIUS_W = 31;
	localparam int unsigned RANK_W = 12;
	localparam int unsigned INDEX_W = 12;
	localparam int unsigned AXIS_W = 2;

	localparam logic [CFG_IW-1:0] REG_SLICES_X = 2'd0;
	localparam logic [CFG_IW-1:0] REG_SLICES_Y = 2'd1;
	localparam logic [CFG_IW-1:0] REG_SLICES_Z = 2'd2;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	typedef enum logic [1:0] {
		OP_WR_BOUND = 2'd0,
		OP_WR_MAP   = 2'd1,
		OP_QUERY    = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_CTR = 2'd0,
		KIND_LO  = 2'd1,
		KIND_HI  = 2'd2
	} kind_t;

	typedef struct packed {
		logic wr_bound;
		logic wr_map;
		logic load;
		logic srch_rd;
		logic srch_upd;
		logic srch_next;
		logic cell_ctr;
		logic idx1;
		logic idx2;
		logic map_rd;
		logic ctr_cap;
		logic found_set;
		logic scan_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic srch_more;
		logic srch_last;
		logic scan_empty;
		logic scan_last;
		logic match;
		logic out_free;
	} st_t;

endpackage

// ===== rtl/pbrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pbrl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/pbrl_ctrl.sv =====
// Controller state machine sequencing writes, slice searches and the box scan.
module pbrl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic [1:0]     operation,
	output logic           s_tready,
	output pbrl_pkg::cmd_t cmd,
	input  pbrl_pkg::st_t  st
);

	import pbrl_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_SRCH_CMP,
		S_CELL_SET,
		S_CELL_IDX1,
		S_CELL_IDX2,
		S_CELL_RD,
		S_CELL_CHK
	} state_t;

	state_t state_q;
	logic   scan_q;
	logic   done_q;
	logic   accept;

	assign s_tready = (state_q == S_IDLE) && !done_q;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (done_q) begin
					cmd.out_load = st.out_free;
				end else if (accept) begin
					case (op_t'(operation))
						OP_WR_BOUND: cmd.wr_bound = 1'b1;
						OP_WR_MAP:   cmd.wr_map   = 1'b1;
						OP_QUERY:    cmd.load     = 1'b1;
						default:     cmd.load     = 1'b0;
					endcase
				end
			end
			S_SRCH: begin
				if (st.srch_more) begin
					cmd.srch_rd = 1'b1;
				end else begin
					cmd.srch_next = 1'b1;
				end
			end
			S_SRCH_CMP:  cmd.srch_upd = 1'b1;
			S_CELL_SET:  cmd.cell_ctr = 1'b1;
			S_CELL_IDX1: cmd.idx1     = 1'b1;
			S_CELL_IDX2: cmd.idx2     = 1'b1;
			S_CELL_RD:   cmd.map_rd   = 1'b1;
			S_CELL_CHK: begin
				if (!scan_q) begin
					cmd.ctr_cap = 1'b1;
				end else if (st.match) begin
					cmd.found_set = 1'b1;
				end else if (!st.scan_last) begin
					cmd.scan_step = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (done_q) begin
						if (st.out_free) begin
							done_q <= 1'b0;
						end
					end else if (accept && op_t'(operation) == OP_QUERY) begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (st.srch_more) begin
						state_q <= S_SRCH_CMP;
					end else if (st.srch_last) begin
						state_q <= S_CELL_SET;
					end
				end
				S_SRCH_CMP: state_q <= S_SRCH;
				S_CELL_SET: begin
					scan_q  <= 1'b0;
					state_q <= S_CELL_IDX1;
				end
				S_CELL_IDX1: state_q <= S_CELL_IDX2;
				S_CELL_IDX2: state_q <= S_CELL_RD;
				S_CELL_RD:   state_q <= S_CELL_CHK;
				S_CELL_CHK: begin
					if (!scan_q) begin
						if (st.scan_empty) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							scan_q  <= 1'b1;
							state_q <= S_CELL_IDX1;
						end
					end else if (st.match || st.scan_last) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CELL_IDX1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/pbrl_dp.sv =====
// Datapath: slice counts, boundary and rank memories, search and scan registers.
module pbrl_dp #(
	parameter int unsigned MAX_SLICES = 16,
	parameter int unsigned MAX_RANKS  = 4096
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [pbrl_pkg::CFG_IW-1:0]            cfg_index,
	input  logic [pbrl_pkg::CFG_DW-1:0]            cfg_data,
	input  logic [pbrl_pkg::AXIS_W-1:0]            axis,
	input  logic [pbrl_pkg::INDEX_W-1:0]           entry_index,
	input  logic signed [pbrl_pkg::COORD_W-1:0]    boundary_value,
	input  logic [pbrl_pkg::RANK_W-1:0]            map_rank,
	input  logic signed [pbrl_pkg::COORD_W-1:0]    point_x,
	input  logic signed [pbrl_pkg::COORD_W-1:0]    point_y,
	input  logic signed [pbrl_pkg::COORD_W-1:0]    point_z,
	input  logic [pbrl_pkg::RADIUS_W-1:0]          radius,
	input  logic [pbrl_pkg::RANK_W-1:0]            target_rank,
	input  pbrl_pkg::cmd_t                         cmd,
	output pbrl_pkg::st_t                          st,
	input  logic                                   m_tready,
	output logic                                   m_tvalid,
	output logic [pbrl_pkg::RANK_W-1:0]            center_rank,
	output logic                                   target_found
);

	import pbrl_pkg::*;

	localparam int unsigned SW     = $clog2(MAX_SLICES);
	localparam int unsigned CW     = $clog2(MAX_SLICES + 1);
	localparam int unsigned IW     = 3 * SW;
	localparam int unsigned BDEPTH = 3 * MAX_SLICES;
	localparam int unsigned BAW    = $clog2(BDEPTH);
	localparam int unsigned RAW    = $clog2(MAX_RANKS);

	logic [CFG_DW-1:0] slices_q [3];
	logic [SW-1:0]     last_d [3];
	logic [CW-1:0]     ny, nz;

	logic signed [COORD_W-1:0] point_q [3];
	logic [RADIUS_W-1:0]       radius_q;
	logic [RANK_W-1:0]         target_q;

	logic [AXIS_W-1:0] axis_q;
	kind_t             kind_q;
	logic [SW-1:0]     lo_q, hi_q;
	logic [SW:0]       sum;
	logic [SW-1:0]     mid;
	logic [SW-1:0]     ctr_q [3];
	logic [SW-1:0]     blo_q [3];
	logic [SW-1:0]     bhi_q [3];
	logic [SW-1:0]     cur_q [3];

	logic signed [COORD_W:0] pt_w, rad_w, coord, bnd_w;
	logic                    bnd_le;

	logic [2*SW-1:0] cx_w, ny_w, cy_w, t_d, t_q;
	logic [IW-1:0]   t_w, nz_w, cz_w, idx_d, idx_q;
	logic            oor_q;
	logic [31:0]     idx_ext, widx_ext, bw_ext, br_ext;

	logic [COORD_W-1:0] b_rdata;
	logic [RANK_W-1:0]  m_rdata, rank_val;
	logic               bnd_we, map_we;

	logic [RANK_W-1:0] center_q, out_rank_q;
	logic              found_q, out_found_q, out_valid_q;

	function automatic logic [SW-1:0] eff_last(input logic [CFG_DW-1:0] v);
		logic [SW-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (32'(v) > 32'(MAX_SLICES)) begin
			r = SW'(MAX_SLICES - 1);
		end else begin
			r = SW'(v - CFG_DW'(1));
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slices_q[0] <= CFG_DW'(1);
			slices_q[1] <= CFG_DW'(1);
			slices_q[2] <= CFG_DW'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLICES_X: slices_q[0] <= cfg_data;
				REG_SLICES_Y: slices_q[1] <= cfg_data;
				REG_SLICES_Z: slices_q[2] <= cfg_data;
				default:      slices_q[0] <= slices_q[0];
			endcase
		end
	end

	always_comb begin
		for (int d = 0; d < 3; d++) begin
			last_d[d] = eff_last(slices_q[d]);
		end
	end

	assign ny = CW'(last_d[1]) + CW'(1);
	assign nz = CW'(last_d[2]) + CW'(1);

	// boundary store
	assign bnd_we   = cmd.wr_bound && axis <= AXIS_Z && 32'(entry_index) < 32'(MAX_SLICES);
	assign bw_ext   = 32'(axis) * 32'(MAX_SLICES) + 32'(entry_index);
	assign br_ext   = 32'(axis_q) * 32'(MAX_SLICES) + 32'(mid);

	pbrl_ram #(
		.WIDTH(COORD_W),
		.DEPTH(BDEPTH)
	) u_bound_ram (
		.clk  (clk),
		.we   (bnd_we),
		.waddr(bw_ext[BAW-1:0]),
		.wdata(boundary_value),
		.re   (cmd.srch_rd),
		.raddr(br_ext[BAW-1:0]),
		.rdata(b_rdata)
	);

	// rank map store
	assign widx_ext = 32'(entry_index);
	assign map_we   = cmd.wr_map && widx_ext < 32'(MAX_RANKS);
	assign idx_ext  = 32'(idx_q);

	pbrl_ram #(
		.WIDTH(RANK_W),
		.DEPTH(MAX_RANKS)
	) u_map_ram (
		.clk  (clk),
		.we   (map_we),
		.waddr(widx_ext[RAW-1:0]),
		.wdata(map_rank),
		.re   (cmd.map_rd),
		.raddr(idx_ext[RAW-1:0]),
		.rdata(m_rdata)
	);

	// binary search
	assign sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = sum[SW:1];

	always_comb begin
		case (axis_q)
			AXIS_X:  pt_w = {point_q[0][COORD_W-1], point_q[0]};
			AXIS_Y:  pt_w = {point_q[1][COORD_W-1], point_q[1]};
			default: pt_w = {point_q[2][COORD_W-1], point_q[2]};
		endcase
		rad_w = {2'b00, radius_q};
		case (kind_q)
			KIND_CTR: coord = pt_w;
			KIND_LO:  coord = pt_w - rad_w;
			default:  coord = pt_w + rad_w;
		endcase
	end

	assign bnd_w  = {b_rdata[COORD_W-1], b_rdata};
	assign bnd_le = coord <= bnd_w;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			point_q[0] <= point_x;
			point_q[1] <= point_y;
			point_q[2] <= point_z;
			radius_q   <= radius;
			target_q   <= target_rank;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			axis_q <= AXIS_X;
			kind_q <= KIND_CTR;
			lo_q   <= '0;
			hi_q   <= last_d[0];
		end else if (cmd.srch_upd) begin
			if (bnd_le) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + SW'(1);
			end
		end else if (cmd.srch_next) begin
			case (kind_q)
				KIND_CTR: ctr_q[axis_q] <= lo_q;
				KIND_LO:  blo_q[axis_q] <= lo_q;
				default:  bhi_q[axis_q] <= lo_q;
			endcase
			lo_q <= '0;
			case (kind_q)
				KIND_CTR: begin
					kind_q <= KIND_LO;
					hi_q   <= last_d[axis_q];
				end
				KIND_LO: begin
					kind_q <= KIND_HI;
					hi_q   <= last_d[axis_q];
				end
				default: begin
					kind_q <= KIND_CTR;
					axis_q <= axis_q + AXIS_W'(1);
					hi_q   <= (axis_q == AXIS_X) ? last_d[1] : last_d[2];
				end
			endcase
		end
	end

	// cell walk
	always_ff @(posedge clk) begin
		if (cmd.cell_ctr) begin
			for (int d = 0; d < 3; d++) begin
				cur_q[d] <= ctr_q[d];
			end
		end else if (cmd.ctr_cap) begin
			for (int d = 0; d < 3; d++) begin
				cur_q[d] <= blo_q[d];
			end
		end else if (cmd.scan_step) begin
			if (cur_q[2] != bhi_q[2]) begin
				cur_q[2] <= cur_q[2] + SW'(1);
			end else begin
				cur_q[2] <= blo_q[2];
				if (cur_q[1] != bhi_q[1]) begin
					cur_q[1] <= cur_q[1] + SW'(1);
				end else begin
					cur_q[1] <= blo_q[1];
					cur_q[0] <= cur_q[0] + SW'(1);
				end
			end
		end
	end

	assign cx_w  = (2*SW)'(cur_q[0]);
	assign ny_w  = (2*SW)'(ny);
	assign cy_w  = (2*SW)'(cur_q[1]);
	assign t_d   = cx_w * ny_w + cy_w;
	assign t_w   = IW'(t_q);
	assign nz_w  = IW'(nz);
	assign cz_w  = IW'(cur_q[2]);
	assign idx_d = t_w * nz_w + cz_w;

	always_ff @(posedge clk) begin
		if (cmd.idx1) begin
			t_q <= t_d;
		end
		if (cmd.idx2) begin
			idx_q <= idx_d;
			oor_q <= 32'(idx_d) >= 32'(MAX_RANKS);
		end
	end

	assign rank_val = oor_q ? '0 : m_rdata;

	always_ff @(posedge clk) begin
		if (cmd.ctr_cap) begin
			center_q <= rank_val;
		end
		if (cmd.load) begin
			found_q <= 1'b0;
		end else if (cmd.found_set) begin
			found_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_rank_q  <= center_q;
			out_found_q <= found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		st.srch_more  = lo_q < hi_q;
		st.srch_last  = (axis_q == AXIS_Z) && (kind_q == KIND_HI);
		st.scan_empty = (blo_q[0] > bhi_q[0]) || (blo_q[1] > bhi_q[1])
			|| (blo_q[2] > bhi_q[2]);
		st.scan_last  = (cur_q[0] == bhi_q[0]) && (cur_q[1] == bhi_q[1])
			&& (cur_q[2] == bhi_q[2]);
		st.match      = rank_val == target_q;
		st.out_free   = !out_valid_q || m_tready;
	end

	assign m_tvalid     = out_valid_q;
	assign center_rank  = out_rank_q;
	assign target_found = out_found_q;

endmodule

// ===== rtl/point_box_to_rank_lookup_top.sv =====
// Top level of the point box to rank lookup block.
//
//  Channel   Direction  Content
//  s_*       in         one request: s_tuser operation, s_tdata write or query fields
//  m_*       out        one result per query: center rank and target found flag
//  cfg_*     in         slice count register writes, no read-back
//
// Boundary and map writes go straight into their memories. A query runs nine binary
// searches, each step one boundary memory read and compare, then reads the center cell
// and scans the box cells, each through the index multiplies and the rank map read,
// ending at the first match, at the last cell, or at once if the box is empty.
// Reset clears control and sets each slice count to one; the memories hold no reset value.
// A result waits in the output register while the next request is taken.
module point_box_to_rank_lookup_top #(
	parameter int unsigned MAX_SLICES = 16,
	parameter int unsigned MAX_RANKS  = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// axis[1:0] entry_index[13:2] boundary_value[45:14] map_rank[57:46]
	// point_x[89:58] point_y[121:90] point_z[153:122] radius[184:154]
	// target_rank[196:185], zero fill above
	input  logic [199:0]                     s_tdata,
	// operation[1:0]
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// center_rank[11:0] target_found[12], zero fill above
	output logic [15:0]                      m_tdata,
	input  logic                             cfg_we,
	input  logic [pbrl_pkg::CFG_IW-1:0]      cfg_index,
	input  logic [pbrl_pkg::CFG_DW-1:0]      cfg_data
);

	import pbrl_pkg::*;

	cmd_t              cmd;
	st_t               st;
	logic [RANK_W-1:0] center_rank;
	logic              target_found;

	pbrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.operation(s_tuser),
		.s_tready (s_tready),
		.cmd      (cmd),
		.st       (st)
	);

	pbrl_dp #(
		.MAX_SLICES(MAX_SLICES),
		.MAX_RANKS (MAX_RANKS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.axis          (s_tdata[1:0]),
		.entry_index   (s_tdata[13:2]),
		.boundary_value(s_tdata[45:14]),
		.map_rank      (s_tdata[57:46]),
		.point_x       (s_tdata[89:58]),
		.point_y       (s_tdata[121:90]),
		.point_z       (s_tdata[153:122]),
		.radius        (s_tdata[184:154]),
		.target_rank   (s_tdata[196:185]),
		.cmd           (cmd),
		.st            (st),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.center_rank   (center_rank),
		.target_found  (target_found)
	);

	assign m_tdata = {3'b000, target_found, center_rank};

endmodule
